/* rtl/core/binodal_phase_classifier_assert.svh */
// Assertion macros shared by the classifier RTL
`ifndef BINODAL_PHASE_CLASSIFIER_ASSERT_SVH
`define BINODAL_PHASE_CLASSIFIER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bpc_pkg.sv */
`timescale 1ns / 1ps

package bpc_pkg;

    // Fixed field widths
    localparam int DATA_W         = 32;
    localparam int PHASE_W        = 2;
    localparam int SEG_W          = 6;
    localparam int PT_IDX_W       = 6;
    localparam int PIU_W          = 7;
    localparam int CFG_ADDR_W     = 4;
    localparam int DEF_MAX_POINTS = 64;

    localparam logic [PIU_W-1:0] PIU_RESET = 7'd2;

    // Input transaction opcodes
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    // Phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_SCF,
        PH_GAS,
        PH_MIX,
        PH_LIQ
    } t_phase;

    // Register indexes (word address bits [3:2])
    typedef enum logic [1:0] {
        CFG_CRIT_T,
        CFG_CRIT_P,
        CFG_CRIT_V,
        CFG_POINTS
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_RESULT
    } t_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [DATA_W-1:0] crit_t;
        logic [DATA_W-1:0] crit_p;
        logic [DATA_W-1:0] crit_v;
        logic [PIU_W-1:0]  points;
    } t_cfg;

    // One binodal table entry
    typedef struct packed {
        logic [DATA_W-1:0] pressure;
        logic [DATA_W-1:0] left_volume;
        logic [DATA_W-1:0] right_volume;
    } t_point;

endpackage

/* rtl/core/bpc_if.sv */
`timescale 1ns / 1ps

// Input channel: classify request or table point write
interface bpc_in_if;
    import bpc_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [DATA_W-1:0]   volume;
    logic [DATA_W-1:0]   pressure;
    logic [DATA_W-1:0]   temperature;
    logic [PT_IDX_W-1:0] point_index;
    logic [DATA_W-1:0]   point_pressure;
    logic [DATA_W-1:0]   point_left_volume;
    logic [DATA_W-1:0]   point_right_volume;

    modport source (
        output valid, op, volume, pressure, temperature, point_index,
               point_pressure, point_left_volume, point_right_volume,
        input  ready
    );
    modport sink (
        input  valid, op, volume, pressure, temperature, point_index,
               point_pressure, point_left_volume, point_right_volume,
        output ready
    );
endinterface

// Output channel: classification result
interface bpc_out_if;
    import bpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic [SEG_W-1:0]   segment;

    modport source (
        output valid, phase, segment,
        input  ready
    );
    modport sink (
        input  valid, phase, segment,
        output ready
    );
endinterface

/* rtl/core/bpc_regs.sv */
`timescale 1ns / 1ps

module bpc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
    output logic [bpc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output bpc_pkg::t_cfg                   o_cfg
);
    import bpc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_cfg_idx reg_sel;
    logic     wr_en;

    assign reg_sel = t_cfg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                CFG_CRIT_T: n_cfg.crit_t = pwdata;
                CFG_CRIT_P: n_cfg.crit_p = pwdata;
                CFG_CRIT_V: n_cfg.crit_v = pwdata;
                CFG_POINTS: n_cfg.points = pwdata[PIU_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crit_t <= '0;
            r_cfg.crit_p <= '0;
            r_cfg.crit_v <= '0;
            r_cfg.points <= PIU_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux
    always_comb begin
        case (reg_sel)
            CFG_CRIT_T: prdata = r_cfg.crit_t;
            CFG_CRIT_P: prdata = r_cfg.crit_p;
            CFG_CRIT_V: prdata = r_cfg.crit_v;
            CFG_POINTS: prdata = {{(DATA_W-PIU_W){1'b0}}, r_cfg.points};
            default:    prdata = '0;
        endcase
    end

endmodule

/* rtl/core/binodal_phase_classifier.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    op, volume, pressure, temperature, point_index,
//                               point_pressure, point_left_volume, point_right_volume
// o_out     out  valid/ready    phase, segment
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// A table write does not leave idle; the block stays ready for the next transaction.
// A classify at or above the critical temperature, or one with fewer than two points
// in use, goes from the check state straight to the result state.
// Otherwise the table memory is scanned one entry a cycle from point 0; a hit at
// point i goes on through the multiply and compare states to the result state, and
// a pressure under all n points in use goes from the scan straight to the result state.
// Reset is synchronous, active low, and needs no clearing pass.
// One classify is in flight at a time; a held result keeps the next classify in
// its result state, and the input stays stalled until the output frees.

`include "binodal_phase_classifier_assert.svh"

module binodal_phase_classifier #(
    parameter int MAX_POINTS = bpc_pkg::DEF_MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
    output logic [bpc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    bpc_in_if.sink                          i_in,
    bpc_out_if.source                       o_out
);
    import bpc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    t_cfg cfg;

    // Table memory and read port
    t_point          r_table [MAX_POINTS];
    t_point          r_rd;
    logic [AW-1:0]   rd_addr;
    logic            tbl_we;
    logic [AW-1:0]   tbl_wa;
    t_point          tbl_wd;

    // Sequencer
    t_state r_state, n_state;
    logic   in_acc;
    logic   out_acc;

    // Transaction and scan registers
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_p, n_p;
    logic [DATA_W-1:0] r_t, n_t;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     n_eff;
    t_point            r_prev, n_prev;

    // Compare operands
    logic [DATA_W-1:0]   r_a, n_a;
    logic [DATA_W-1:0]   r_b, n_b;
    logic [DATA_W-1:0]   r_dmag, n_dmag;
    logic [DATA_W-1:0]   r_num, n_num;
    logic                r_aneg, n_aneg;
    logic                r_rneg, n_rneg;
    logic                r_left, n_left;
    logic [2*DATA_W-1:0] r_lmag, n_lmag;
    logic [2*DATA_W-1:0] r_rmag, n_rmag;

    // Result staging and output register
    t_phase           r_res_phase, n_res_phase;
    logic [SEG_W-1:0] r_res_seg, n_res_seg;
    logic             r_o_valid, n_o_valid;
    t_phase           r_o_phase, n_o_phase;
    logic [SEG_W-1:0] r_o_seg, n_o_seg;

    // Segment differences
    logic              sel_left;
    logic [DATA_W-1:0] v_cur, v_prev;
    logic              d_neg, a_neg, b_neg;
    logic [DATA_W-1:0] d_mag, a_mag, b_mag;
    logic              hit;

    // Sign-magnitude compare
    logic l_neg_eff, r_neg_eff, mag_lt, mag_gt, is_lt, is_gt;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_acc      = i_in.valid && i_in.ready;
    assign out_acc     = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_o_valid;
    assign o_out.phase = r_o_phase;
    assign o_out.segment = r_o_seg;

    // Points in use, clamped to the table depth
    assign n_eff = (32'(cfg.points) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cfg.points);

    // Table writes only happen in idle, so they never overlap a scan read
    assign tbl_we = in_acc && (i_in.op == OP_WRITE)
                    && (32'(i_in.point_index) < 32'(MAX_POINTS));
    assign tbl_wa = AW'(i_in.point_index);
    assign tbl_wd = '{pressure:     i_in.point_pressure,
                      left_volume:  i_in.point_left_volume,
                      right_volume: i_in.point_right_volume};
    // Read one entry ahead of the entry being examined
    assign rd_addr = (r_state == ST_SCAN) ? AW'(r_idx + CW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_wa] <= tbl_wd;
        end
        r_rd <= r_table[rd_addr];
    end

    // Branch selection and segment differences
    assign sel_left = r_v < cfg.crit_v;
    assign v_cur    = sel_left ? r_rd.left_volume   : r_rd.right_volume;
    assign v_prev   = sel_left ? r_prev.left_volume : r_prev.right_volume;
    assign d_neg    = r_prev.pressure < r_rd.pressure;
    assign d_mag    = d_neg ? (r_rd.pressure - r_prev.pressure)
                            : (r_prev.pressure - r_rd.pressure);
    assign a_neg    = r_v < v_cur;
    assign a_mag    = a_neg ? (v_cur - r_v) : (r_v - v_cur);
    assign b_neg    = v_prev < v_cur;
    assign b_mag    = b_neg ? (v_cur - v_prev) : (v_prev - v_cur);
    assign hit      = (r_idx != '0) && (r_rd.pressure <= r_p);

    // Sign of (volume - interpolated volume); zero magnitudes count as positive
    assign l_neg_eff = r_aneg && (r_lmag != '0);
    assign r_neg_eff = r_rneg && (r_rmag != '0);
    assign mag_lt    = r_lmag < r_rmag;
    assign mag_gt    = r_lmag > r_rmag;
    assign is_lt     = l_neg_eff ? (!r_neg_eff || mag_gt) : (!r_neg_eff && mag_lt);
    assign is_gt     = l_neg_eff ? (r_neg_eff && mag_lt) : (r_neg_eff || mag_gt);

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_p         = r_p;
        n_t         = r_t;
        n_n         = r_n;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_a         = r_a;
        n_b         = r_b;
        n_dmag      = r_dmag;
        n_num       = r_num;
        n_aneg      = r_aneg;
        n_rneg      = r_rneg;
        n_left      = r_left;
        n_lmag      = r_lmag;
        n_rmag      = r_rmag;
        n_res_phase = r_res_phase;
        n_res_seg   = r_res_seg;
        n_o_valid   = r_o_valid;
        n_o_phase   = r_o_phase;
        n_o_seg     = r_o_seg;

        if (out_acc) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in.op == OP_CLASSIFY)) begin
                    n_v     = i_in.volume;
                    n_p     = i_in.pressure;
                    n_t     = i_in.temperature;
                    n_n     = n_eff;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_res_seg = '0;
                if (r_t >= cfg.crit_t) begin
                    n_res_phase = (r_p >= cfg.crit_p) ? PH_SCF : PH_GAS;
                    n_state     = ST_RESULT;
                end else if (r_n < CW'(2)) begin
                    n_res_phase = (r_v <= cfg.crit_v) ? PH_MIX : PH_GAS;
                    n_state     = ST_RESULT;
                end else begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_prev = r_rd;
                n_idx  = r_idx + CW'(1);
                if (hit) begin
                    n_a       = a_mag;
                    n_aneg    = a_neg;
                    n_b       = b_mag;
                    n_rneg    = b_neg != d_neg;
                    n_left    = sel_left;
                    n_res_seg = SEG_W'(r_idx);
                    // flat segment: interpolated volume is the lower point's
                    if (d_mag == '0) begin
                        n_dmag = DATA_W'(1);
                        n_num  = '0;
                    end else begin
                        n_dmag = d_mag;
                        n_num  = r_p - r_rd.pressure;
                    end
                    n_state = ST_MUL;
                end else if (r_idx == r_n - CW'(1)) begin
                    // below every point: low-pressure rule
                    n_res_phase = (r_v <= cfg.crit_v) ? PH_MIX : PH_GAS;
                    n_res_seg   = '0;
                    n_state     = ST_RESULT;
                end
            end
            ST_MUL: begin
                n_lmag  = (2*DATA_W)'(r_a) * (2*DATA_W)'(r_dmag);
                n_rmag  = (2*DATA_W)'(r_b) * (2*DATA_W)'(r_num);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_left) begin
                    n_res_phase = is_lt ? PH_LIQ : PH_MIX;
                end else begin
                    n_res_phase = is_gt ? PH_GAS : PH_MIX;
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_phase = r_res_phase;
                    n_o_seg   = r_res_seg;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_p         <= n_p;
        r_t         <= n_t;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_prev      <= n_prev;
        r_a         <= n_a;
        r_b         <= n_b;
        r_dmag      <= n_dmag;
        r_num       <= n_num;
        r_aneg      <= n_aneg;
        r_rneg      <= n_rneg;
        r_left      <= n_left;
        r_lmag      <= n_lmag;
        r_rmag      <= n_rmag;
        r_res_phase <= n_res_phase;
        r_res_seg   <= n_res_seg;
        r_o_phase   <= n_o_phase;
        r_o_seg     <= n_o_seg;
    end

    // Checks
    `BPC_ASSERT_IMP(a_scan_in_table, i_clk, i_rst_n, r_state == ST_SCAN, r_idx < r_n, "scan ran past the points in use")
    `BPC_ASSERT_IMP(a_mul_after_hit, i_clk, i_rst_n, r_state == ST_MUL, $past(r_state) == ST_SCAN, "multiply entered without a segment hit")
    `BPC_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, in_acc && (i_in.op == OP_WRITE), (r_state == ST_IDLE) && !$rose(r_o_valid), "table write produced a result")
    `BPC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == ST_RESULT) && r_o_valid && !o_out.ready, r_state == ST_RESULT, "result overwrote a pending output")

endmodule
